/* rtl/dht_pkg.sv */
// ----------------------------------------------------------------------------
// dht_pkg: shared types and constants of the double hashing table
// Field widths, action codes and reset values used by the interfaces and RTL.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 31;
    localparam int FIELD_W  = 13;

    typedef logic [ACTION_W-1:0] t_action;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [FIELD_W-1:0]  t_field;

    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_SEARCH = 2'd1;
    localparam t_action ACT_CLEAR  = 2'd2;

    // initial size register value after reset
    localparam t_field INIT_SIZE_RST = 13'd16;

endpackage

/* rtl/dht_if.sv */
// ----------------------------------------------------------------------------
// dht_if: request and response channels of the double hashing table
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dht_in_if;
    logic             valid;
    logic             ready;
    dht_pkg::t_action action;
    dht_pkg::t_key    key;

    modport source (output valid, action, key, input ready);
    modport sink   (input valid, action, key, output ready);
endinterface

interface dht_out_if;
    logic            valid;
    logic            ready;
    dht_pkg::t_field comparisons;
    logic            status;
    dht_pkg::t_field table_size;
    dht_pkg::t_field fill_count;

    modport source (output valid, comparisons, status, table_size, fill_count, input ready);
    modport sink   (input valid, comparisons, status, table_size, fill_count, output ready);
endinterface

/* rtl/double_hashing_table_with_rehash.sv */
// Order of work: a search or insert reduces the key, then probes the slot memory; on
//   growth an insert first gathers and zeroes the table and re-places each moved key.
// A clear sweeps the slot memory; other actions go straight to the result. One word at a time:
//   the 31-step remainder unit and the slot memory read of S_PRD and S_PCHK set it.
// Reset: synchronous, active low; afterwards a clearing pass sweeps every slot
//   of the slot memory with ready low; configuration writes are still taken.
// ----------------------------------------------------------------------------
// double_hashing_table_with_rehash: open-addressing hash table, double hashing
// Slot memory with read-modify-write probing, growth by doubling with rehash.
// ----------------------------------------------------------------------------
module double_hashing_table_with_rehash #(
    parameter int CAPACITY = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  dht_pkg::t_field        i_cfg_wdata,
    dht_in_if.sink                 i_in,
    dht_out_if.source              o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = AW + 1;
    localparam int RW = SW + 1;
    localparam int GW = SW + 3;
    localparam int KW = dht_pkg::KEY_W;
    localparam int CW = $clog2(KW);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_GRD, S_GCHK, S_ZERO, S_RRD, S_RWAIT,
        S_DIV, S_PRD, S_PCHK, S_DONE
    } t_state;

    function automatic logic [SW-1:0] clamp_size(input dht_pkg::t_field v);
        logic [31:0] t;
        t = 32'(v);
        if (t < 32'd2) t = 32'd2;
        if (t > 32'(CAPACITY)) t = 32'(CAPACITY);
        return SW'(t);
    endfunction

    // memories
    logic [KW:0]   slot_mem [CAPACITY];
    logic [KW-1:0] scr_mem  [CAPACITY];
    logic [KW:0]   slot_rd;
    logic [KW-1:0] scr_rd;

    t_state           r_state;
    dht_pkg::t_action r_act;
    dht_pkg::t_key    r_key;
    dht_pkg::t_key    r_dkey;
    logic             r_reins;
    logic             r_from_rst;
    logic [SW-1:0]    r_s, r_n, r_j, r_i;
    logic [SW-1:0]    r_size, r_count, r_cmp;
    dht_pkg::t_field  r_init;
    logic [AW-1:0]    r_pos, r_step;
    logic [CW-1:0]    r_dcnt;
    logic [RW-1:0]    r_ra, r_rb;
    logic [KW-1:0]    r_dsh;
    logic             r_status;
    logic             r_ov;
    dht_pkg::t_field  r_o_cmp, r_o_size, r_o_count;
    logic             r_o_status;

    // memory access controls
    logic             slot_we;
    logic [AW-1:0]    slot_waddr, slot_raddr;
    logic [KW:0]      slot_wdata;
    logic             scr_we;
    logic [AW-1:0]    scr_waddr;

    // remainder steps, growth test, probe walk
    logic [SW-1:0] half;
    logic [RW-1:0] ta, tb, na, nb;
    logic [GW-1:0] g_lhs, g_rhs;
    logic          grow;
    logic [SW-1:0] psum, pnext;
    logic          placing, occ, hit;

    assign half  = r_size >> 1;
    assign ta    = {r_ra[RW-2:0], r_dsh[KW-1]};
    assign tb    = {r_rb[RW-2:0], r_dsh[KW-1]};
    assign na    = (ta >= RW'(r_size)) ? ta - RW'(r_size) : ta;
    assign nb    = (tb >= RW'(half))   ? tb - RW'(half)   : tb;
    assign g_lhs = (GW'(r_count) + GW'(1)) << 2;
    assign g_rhs = (GW'(r_size) << 1) + GW'(r_size);
    assign grow  = (g_lhs >= g_rhs) && ((GW'(r_size) << 1) <= GW'(CAPACITY));
    assign psum  = SW'(r_pos) + SW'(r_step);
    assign pnext = (psum >= r_size) ? psum - r_size : psum;
    assign placing = r_reins || (r_act == dht_pkg::ACT_INSERT);
    assign occ   = slot_rd[KW];
    assign hit   = occ && (slot_rd[KW-1:0] == r_dkey);

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_s[AW-1:0];
        slot_wdata = '0;
        slot_raddr = r_pos;
        scr_we     = 1'b0;
        scr_waddr  = r_n[AW-1:0];
        case (r_state)
            S_CLR, S_ZERO: begin
                slot_we = 1'b1;
            end
            S_GRD: begin
                slot_raddr = r_s[AW-1:0];
            end
            S_GCHK: begin
                slot_we = 1'b1;
                scr_we  = occ;
            end
            S_PCHK: begin
                slot_waddr = r_pos;
                slot_wdata = {1'b1, r_dkey};
                slot_we    = placing && !occ;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd <= slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            scr_mem[scr_waddr] <= slot_rd[KW-1:0];
        end
        scr_rd <= scr_mem[r_j[AW-1:0]];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= dht_pkg::INIT_SIZE_RST;
        end else if (i_cfg_we) begin
            r_init <= i_cfg_wdata;
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.comparisons = r_o_cmp;
    assign o_out.status      = r_o_status;
    assign o_out.table_size  = r_o_size;
    assign o_out.fill_count  = r_o_count;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_from_rst <= 1'b1;
            r_s        <= '0;
            r_size     <= clamp_size(dht_pkg::INIT_SIZE_RST);
            r_count    <= '0;
            r_reins    <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            // S_DONE always leaves a word in the output register
            if (o_out.ready && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_act    <= i_in.action;
                        r_key    <= i_in.key;
                        r_dkey   <= i_in.key;
                        r_reins  <= 1'b0;
                        r_cmp    <= '0;
                        r_status <= 1'b0;
                        r_ra     <= '0;
                        r_rb     <= '0;
                        r_dsh    <= i_in.key;
                        r_dcnt   <= CW'(KW - 1);
                        r_s      <= '0;
                        r_n      <= '0;
                        case (i_in.action)
                            dht_pkg::ACT_INSERT: r_state <= grow ? S_GRD : S_DIV;
                            dht_pkg::ACT_SEARCH: r_state <= S_DIV;
                            dht_pkg::ACT_CLEAR: begin
                                r_size     <= clamp_size(r_init);
                                r_count    <= '0;
                                r_from_rst <= 1'b0;
                                r_state    <= S_CLR;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                // sweep of the whole slot memory
                S_CLR: begin
                    if (r_s == SW'(CAPACITY - 1)) begin
                        r_state <= r_from_rst ? S_IDLE : S_DONE;
                    end else begin
                        r_s <= r_s + SW'(1);
                    end
                end
                // gather old keys, emptying each slot read
                S_GRD: begin
                    r_state <= S_GCHK;
                end
                S_GCHK: begin
                    if (occ) begin
                        r_n <= r_n + SW'(1);
                    end
                    r_s     <= r_s + SW'(1);
                    r_state <= (r_s == r_size - SW'(1)) ? S_ZERO : S_GRD;
                end
                // empty the upper half of the doubled table
                S_ZERO: begin
                    if (r_s == (r_size << 1) - SW'(1)) begin
                        r_size  <= r_size << 1;
                        r_count <= '0;
                        r_j     <= '0;
                        r_state <= S_RRD;
                    end else begin
                        r_s <= r_s + SW'(1);
                    end
                end
                // next gathered key, or the new key when all are back
                S_RRD: begin
                    if (r_j == r_n) begin
                        r_reins <= 1'b0;
                        r_dkey  <= r_key;
                        r_dsh   <= r_key;
                        r_ra    <= '0;
                        r_rb    <= '0;
                        r_dcnt  <= CW'(KW - 1);
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_RWAIT;
                    end
                end
                S_RWAIT: begin
                    r_reins <= 1'b1;
                    r_dkey  <= scr_rd;
                    r_dsh   <= scr_rd;
                    r_ra    <= '0;
                    r_rb    <= '0;
                    r_dcnt  <= CW'(KW - 1);
                    r_state <= S_DIV;
                end
                // key mod M and key mod M/2, one bit a cycle
                S_DIV: begin
                    r_ra  <= na;
                    r_rb  <= nb;
                    r_dsh <= r_dsh << 1;
                    r_dcnt <= r_dcnt - CW'(1);
                    if (r_dcnt == '0) begin
                        r_pos   <= na[AW-1:0];
                        r_step  <= AW'((nb << 1) + RW'(1));
                        r_i     <= '0;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    r_state <= S_PCHK;
                end
                // probe check
                S_PCHK: begin
                    r_pos   <= pnext[AW-1:0];
                    r_i     <= r_i + SW'(1);
                    r_state <= S_PRD;
                    if (placing) begin
                        if (!occ || r_i == r_size - SW'(1)) begin
                            if (!occ) begin
                                r_count <= r_count + SW'(1);
                            end else if (!r_reins) begin
                                r_status <= 1'b1;
                            end
                            if (r_reins) begin
                                r_j     <= r_j + SW'(1);
                                r_state <= S_RRD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end else begin
                        if (hit) begin
                            r_cmp   <= r_i + SW'(1);
                            r_state <= S_DONE;
                        end else if (!occ) begin
                            r_cmp   <= r_i + SW'(2);
                            r_state <= S_DONE;
                        end else if (r_i == r_size - SW'(1)) begin
                            r_cmp   <= r_size;
                            r_state <= S_DONE;
                        end
                    end
                end
                // result word into the output register
                S_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov       <= 1'b1;
                        r_o_cmp    <= dht_pkg::FIELD_W'(r_cmp);
                        r_o_status <= r_status;
                        r_o_size   <= dht_pkg::FIELD_W'(r_size);
                        r_o_count  <= dht_pkg::FIELD_W'(r_count);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_le_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_size) else $error("fill count exceeds table size");
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PCHK) |-> (SW'(r_pos) < r_size)) else $error("probe outside table");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready) else $error("second word taken");
    a_status_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (o_out.comparisons == '0))
        else $error("drop flag with probe count");
`endif

endmodule

/* sim/double_hashing_table_with_rehash_test.sv */
// ----------------------------------------------------------------------------
// double_hashing_table_with_rehash_test: testbench of the double hashing table
// Drives insert, search, clear and unused-action words under varying stalls, predicts every
// response with a behavioral copy of the table and checks each field in order.
// ----------------------------------------------------------------------------
module double_hashing_table_with_rehash_test;

    localparam int CAP      = 4096;
    localparam int WD_LIMIT = 400000;

    // action code the block ignores
    localparam dht_pkg::t_action ACT_UNUSED = 2'd3;

    typedef struct packed {
        dht_pkg::t_field comparisons;
        logic            status;
        dht_pkg::t_field table_size;
        dht_pkg::t_field fill_count;
    } t_resp;

    // table predictor and queue of expected responses
    class table_scoreboard;
        logic [31:0] slots[CAP];
        logic [30:0] moved[CAP];
        int unsigned size_m, count, init_size;
        t_resp       pending[$];
        int          errors;

        function new();
            init_size = 16;
            errors    = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (slots[s]) slots[s] = '0;
            size_m = (init_size < 2) ? 2 : (init_size > CAP) ? CAP : init_size;
            count  = 0;
        endfunction

        function int unsigned stride(int unsigned k);
            return (2 * (k % (size_m / 2)) + 1) % size_m;
        endfunction

        function bit place(int unsigned k);
            int unsigned p, st;
            p  = k % size_m;
            st = stride(k);
            for (int i = 0; i < size_m; i++) begin
                if (!slots[p][31]) begin
                    slots[p] = {1'b1, k[30:0]};
                    count++;
                    return 1;
                end
                p += st;
                if (p >= size_m) p -= size_m;
            end
            return 0;
        endfunction

        function void grow();
            int unsigned n;
            n = 0;
            for (int s = 0; s < size_m; s++)
                if (slots[s][31]) begin
                    moved[n] = slots[s][30:0];
                    n++;
                end
            size_m *= 2;
            for (int s = 0; s < size_m; s++) slots[s] = '0;
            count = 0;
            for (int s = 0; s < n; s++) void'(place(moved[s]));
        endfunction

        function int unsigned probe_count(int unsigned k);
            int unsigned p, st, c;
            p  = k % size_m;
            st = stride(k);
            c  = 0;
            for (int i = 0; i < size_m; i++) begin
                c++;
                if (slots[p][31] && slots[p][30:0] == k[30:0]) return c;
                if (!slots[p][31]) return c + 1;
                p += st;
                if (p >= size_m) p -= size_m;
            end
            return c;
        endfunction

        // note an accepted request word
        function void note_request(dht_pkg::t_action act, dht_pkg::t_key k);
            t_resp r;
            r = '0;
            if (act == dht_pkg::ACT_INSERT) begin
                if (4 * (count + 1) >= 3 * size_m && 2 * size_m <= CAP) grow();
                if (!place(k)) r.status = 1'b1;
            end else if (act == dht_pkg::ACT_SEARCH) begin
                r.comparisons = dht_pkg::t_field'(probe_count(k));
            end else if (act == dht_pkg::ACT_CLEAR) begin
                wipe();
            end
            r.table_size = dht_pkg::t_field'(size_m);
            r.fill_count = dht_pkg::t_field'(count);
            pending.insert(pending.size(), r);
        endfunction

        // check one response word against the oldest expectation
        function void check_response(t_resp got);
            t_resp e;
            if (pending.size() == 0) begin
                $error("response with no expectation waiting");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.comparisons !== e.comparisons) begin
                $error("comparisons: expected %0d actual %0d", e.comparisons, got.comparisons);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.table_size !== e.table_size) begin
                $error("table_size: expected %0d actual %0d", e.table_size, got.table_size);
                errors++;
            end
            if (got.fill_count !== e.fill_count) begin
                $error("fill_count: expected %0d actual %0d", e.fill_count, got.fill_count);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    dht_pkg::t_field i_cfg_wdata;

    dht_in_if  req_ch ();
    dht_out_if rsp_ch ();

    double_hashing_table_with_rehash dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (req_ch.sink),
        .o_out      (rsp_ch.source)
    );

    table_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  idle_cycles;
    dht_pkg::t_key recent_keys[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) rsp_ch.ready <= 1'b0;
        else if (hold_off) rsp_ch.ready <= 1'b0;
        else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // response checking
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response({rsp_ch.comparisons, rsp_ch.status,
                               rsp_ch.table_size, rsp_ch.fill_count});
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // valid stays up between back-to-back words; dropped only on idle cycles
    task automatic send_word(dht_pkg::t_action act, dht_pkg::t_key k);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.key    <= k;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(act, k);
        if (act == dht_pkg::ACT_INSERT) recent_keys.insert(recent_keys.size(), k);
        if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (CAP + 40) @(posedge i_clk);
    endtask

    task automatic write_size(dht_pkg::t_field v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.init_size = v;
    endtask

    function automatic dht_pkg::t_key pick_key(int unsigned size_hint);
        int r;
        r = $urandom_range(99);
        if (r < 35 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        if (r < 75) return dht_pkg::t_key'($urandom_range(4 * size_hint));
        return dht_pkg::t_key'($urandom());
    endfunction

    task automatic random_phase(int n, int max_keys_before_clear);
        int r;
        dht_pkg::t_key k;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            k = pick_key(sb.size_m);
            if (sb.count >= max_keys_before_clear || r < 2)
                send_word(dht_pkg::ACT_CLEAR, k);
            else if (r < 4) send_word(ACT_UNUSED, k);
            else if (r < 55) send_word(dht_pkg::ACT_INSERT, k);
            else send_word(dht_pkg::ACT_SEARCH, k);
        end
    endtask

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        idle_cycles    = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = dht_pkg::INIT_SIZE_RST;
        req_ch.valid   = 1'b0;
        req_ch.action  = dht_pkg::ACT_INSERT;
        req_ch.key     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: key extremes, duplicates, growth, unused action, clear
        send_word(dht_pkg::ACT_SEARCH, 31'd0);
        send_word(dht_pkg::ACT_INSERT, 31'd0);
        send_word(dht_pkg::ACT_INSERT, 31'h7FFFFFFF);
        send_word(dht_pkg::ACT_INSERT, 31'd0);
        send_word(dht_pkg::ACT_SEARCH, 31'd0);
        send_word(dht_pkg::ACT_SEARCH, 31'h7FFFFFFF);
        send_word(dht_pkg::ACT_SEARCH, 31'h55555555);
        send_word(dht_pkg::ACT_SEARCH, 31'h2AAAAAAA);
        for (int i = 0; i < 12; i++) send_word(dht_pkg::ACT_INSERT, dht_pkg::t_key'(i * 16));
        send_word(dht_pkg::ACT_SEARCH, 31'd176);
        send_word(ACT_UNUSED, 31'h7FFFFFFF);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);

        // smallest table: inserts into a table of two slots force growth
        write_size(13'd2);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);
        send_word(dht_pkg::ACT_INSERT, 31'd3);
        send_word(dht_pkg::ACT_INSERT, 31'd5);
        send_word(dht_pkg::ACT_INSERT, 31'd7);
        send_word(dht_pkg::ACT_SEARCH, 31'd9);
        random_phase(150, 40);

        // out-of-range sizes are clamped
        write_size(13'd0);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);
        random_phase(60, 30);
        write_size(13'h1FFF);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);
        send_word(dht_pkg::ACT_INSERT, 31'd12345);
        send_word(dht_pkg::ACT_SEARCH, 31'd12345);

        // table of four slots under heavy receiver stalls
        write_size(13'd4);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);
        recv_stall_pct = 67;
        random_phase(100, 64);
        recv_stall_pct = 0;

        send_idle_pct = 67;
        write_size(13'd3);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);
        random_phase(250, 48);

        send_idle_pct  = 0;
        recv_stall_pct = 67;
        write_size(13'd5);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);
        random_phase(250, 48);

        send_idle_pct  = 9;
        recv_stall_pct = 9;
        write_size(13'd16);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);
        random_phase(250, 60);

        // receiver holds off while requests keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_size(13'd8);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(30, 40);
        join

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_size(13'd7);
        send_word(dht_pkg::ACT_CLEAR, 31'd0);
        random_phase(200, 64);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* double_hashing_table_with_rehash.f */
rtl/dht_pkg.sv
rtl/dht_if.sv
rtl/double_hashing_table_with_rehash.sv
sim/double_hashing_table_with_rehash_test.sv
